// File: hdl/flt_pkg.sv
package flt_pkg;

	// Result kinds carried on the master-side tuser
	localparam logic [2:0] KIND_COUNTED = 3'd0;
	localparam logic [2:0] KIND_NEW     = 3'd1;
	localparam logic [2:0] KIND_DROPPED = 3'd2;
	localparam logic [2:0] KIND_REPORT  = 3'd3;
	localparam logic [2:0] KIND_EMPTY   = 3'd4;

	// Input command codes on the slave-side tuser
	localparam logic CMD_PACKET = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// Configuration register byte addresses
	localparam logic [2:0] ADDR_TTL_RELOAD = 3'd0;
	localparam logic [7:0] TTL_RESET       = 8'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_P_LOOK,
		ST_P_UPD,
		ST_T_ORD,
		ST_T_ENT,
		ST_T_PROC,
		ST_T_FIN
	} state_t;

	// One stored flow: key, interval counters, instance number and lifetime
	typedef struct packed {
		logic [31:0] addr;
		logic [8:0]  proto;
		logic [15:0] port;
		logic [31:0] bytes;
		logic [31:0] pkts;
		logic [6:0]  inst;
		logic [7:0]  life;
	} entry_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic cap_pkt;
		logic cap_tick;
		logic look;
		logic pkt_emit;
		logic ord_rd;
		logic ent_rd;
		logic kill;
		logic surv;
		logic fin;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_tick;
		logic no_flows;
		logic ord_done;
		logic slot_valid;
		logic life_le1;
		logic pend_v;
		logic out_free;
	} status_t;

endpackage

// File: hdl/flt_ctrl.sv
module flt_ctrl
	import flt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (st.is_tick) begin
						cmd.cap_tick = 1'b1;
						state_d = st.no_flows ? ST_T_FIN : ST_T_ORD;
					end else begin
						cmd.cap_pkt = 1'b1;
						state_d = ST_P_LOOK;
					end
				end
			end
			ST_P_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_P_UPD;
			end
			ST_P_UPD: begin
				if (st.out_free) begin
					cmd.pkt_emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_T_ORD: begin
				if (st.ord_done) begin
					state_d = ST_T_FIN;
				end else begin
					cmd.ord_rd = 1'b1;
					state_d = ST_T_ENT;
				end
			end
			ST_T_ENT: begin
				cmd.ent_rd = 1'b1;
				state_d = ST_T_PROC;
			end
			ST_T_PROC: begin
				if (!st.slot_valid) begin
					state_d = ST_T_ORD;
				end else if (st.life_le1) begin
					cmd.kill = 1'b1;
					state_d = ST_T_ORD;
				end else if (!st.pend_v || st.out_free) begin
					cmd.surv = 1'b1;
					state_d = ST_T_ORD;
				end
			end
			ST_T_FIN: begin
				if (st.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: hdl/flt_dpath.sv
module flt_dpath
	import flt_pkg::*;
#(
	parameter int ENTRIES = 64
)
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic [79:0]  s_tdata,   // src_addr, proto_code, src_port, byte_count
	input  logic [0:0]   s_tuser,   // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // flow_addr, flow_proto, flow_port, flow_bytes,
	                                // flow_pkts, instance_no
	output logic [2:0]   m_tuser,   // kind
	output logic         m_tlast,
	input  logic [7:0]   ttl,
	input  cmd_t         cmd,
	output status_t      st
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	// Captured input item
	logic [31:0] addr_q;
	logic [8:0]  proto_q;
	logic [15:0] port_q;
	logic [16:0] bytes_q;

	// Associative key store and valid bits
	logic [ENTRIES-1:0] valid_q;
	logic [31:0]        key_addr_q  [ENTRIES];
	logic [8:0]         key_proto_q [ENTRIES];
	logic [15:0]        key_port_q  [ENTRIES];

	// Entry and order memories
	entry_t         entry_mem_q [ENTRIES];
	logic [IW-1:0]  order_mem_q [ENTRIES];
	entry_t         rd_q;
	logic [IW-1:0]  ord_rd_q;
	logic [IW-1:0]  slot_q;

	// Lookup results
	logic          hit_q, full_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic [6:0]    same_q;

	// Tick walk
	logic [CW-1:0] order_count_q, k_q, keep_q;
	entry_t        pend_q;
	logic          pend_v_q;

	// Output register
	logic         out_v_q;
	logic [2:0]   out_kind_q;
	entry_t       out_e_q;
	logic         out_last_q;

	logic [ENTRIES-1:0] addr_match, full_match;
	logic [IW-1:0]      hit_idx_c, free_idx_c, rd_addr;
	logic               out_free;
	logic [32:0]        byte_sum, pkt_sum;
	logic [31:0]        byte_sat, pkt_sat;
	entry_t             new_e, upd_e, surv_e;

	// Parallel key compare and priority encoders
	always_comb begin
		hit_idx_c  = '0;
		free_idx_c = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			addr_match[i] = valid_q[i] && (key_addr_q[i] == addr_q);
			full_match[i] = addr_match[i] && (key_proto_q[i] == proto_q)
				&& (key_port_q[i] == port_q);
			if (full_match[i]) hit_idx_c = IW'(i);
			if (!valid_q[i]) free_idx_c = IW'(i);
		end
	end

	assign out_free = !out_v_q || m_tready;
	assign rd_addr  = cmd.ent_rd ? ord_rd_q : hit_idx_c;

	// Saturating counter update for a hit
	assign byte_sum = {1'b0, rd_q.bytes} + {16'd0, bytes_q};
	assign pkt_sum  = {1'b0, rd_q.pkts} + 33'd1;
	assign byte_sat = byte_sum[32] ? '1 : byte_sum[31:0];
	assign pkt_sat  = pkt_sum[32] ? '1 : pkt_sum[31:0];

	always_comb begin
		upd_e       = rd_q;
		upd_e.bytes = byte_sat;
		upd_e.pkts  = pkt_sat;
		new_e       = '{addr: addr_q, proto: proto_q, port: port_q,
			bytes: {15'd0, bytes_q}, pkts: 32'd1, inst: same_q + 7'd1, life: ttl};
		surv_e       = rd_q;
		surv_e.bytes = '0;
		surv_e.pkts  = '0;
		surv_e.life  = (rd_q.bytes != '0) ? ttl : rd_q.life - 8'd1;
	end

	// Memories: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.look || cmd.ent_rd) begin
			rd_q <= entry_mem_q[rd_addr];
		end
		if (cmd.ord_rd) begin
			ord_rd_q <= order_mem_q[k_q[IW-1:0]];
		end
		if (cmd.ent_rd) begin
			slot_q <= ord_rd_q;
		end
		if (cmd.pkt_emit && hit_q) begin
			entry_mem_q[hit_idx_q] <= upd_e;
		end else if (cmd.pkt_emit && !full_q) begin
			entry_mem_q[free_idx_q] <= new_e;
			order_mem_q[order_count_q[IW-1:0]] <= free_idx_q;
			key_addr_q[free_idx_q]  <= addr_q;
			key_proto_q[free_idx_q] <= proto_q;
			key_port_q[free_idx_q]  <= port_q;
		end else if (cmd.surv) begin
			entry_mem_q[slot_q] <= surv_e;
			order_mem_q[keep_q[IW-1:0]] <= slot_q;
		end
	end

	// Input capture, lookup results and pending report payload
	always_ff @(posedge clk) begin
		if (cmd.cap_pkt) begin
			addr_q  <= s_tdata[31:0];
			proto_q <= s_tdata[40:32];
			port_q  <= s_tdata[56:41];
			bytes_q <= s_tdata[73:57];
		end
		if (cmd.look) begin
			hit_q      <= |full_match;
			hit_idx_q  <= hit_idx_c;
			free_idx_q <= free_idx_c;
			full_q     <= &valid_q;
			same_q     <= 7'($countones(addr_match));
		end
		if (cmd.surv) begin
			pend_q <= rd_q;
		end
	end

	// Control state: valid bits, counts and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			order_count_q <= '0;
			k_q           <= '0;
			keep_q        <= '0;
			pend_v_q      <= 1'b0;
			out_v_q       <= 1'b0;
		end else begin
			// A new result loads the output register; otherwise a taken result empties it
			if (cmd.pkt_emit || cmd.fin || (cmd.surv && pend_v_q)) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			if (cmd.pkt_emit) begin
				if (!hit_q && !full_q) begin
					valid_q[free_idx_q] <= 1'b1;
					order_count_q <= order_count_q + CW'(1);
				end
			end
			if (cmd.cap_tick) begin
				k_q      <= '0;
				keep_q   <= '0;
				pend_v_q <= 1'b0;
			end
			if (cmd.ord_rd) k_q <= k_q + CW'(1);
			if (cmd.kill) valid_q[slot_q] <= 1'b0;
			if (cmd.surv) begin
				keep_q   <= keep_q + CW'(1);
				pend_v_q <= 1'b1;
			end
			if (cmd.fin) begin
				order_count_q <= keep_q;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (cmd.pkt_emit) begin
			out_last_q <= 1'b1;
			if (hit_q) begin
				out_kind_q <= KIND_COUNTED;
				out_e_q    <= upd_e;
			end else if (full_q) begin
				out_kind_q <= KIND_DROPPED;
				out_e_q    <= '{addr: addr_q, proto: proto_q, port: port_q,
					bytes: '0, pkts: '0, inst: '0, life: '0};
			end else begin
				out_kind_q <= KIND_NEW;
				out_e_q    <= new_e;
			end
		end else if (cmd.surv && pend_v_q) begin
			out_kind_q <= KIND_REPORT;
			out_e_q    <= pend_q;
			out_last_q <= 1'b0;
		end else if (cmd.fin) begin
			out_last_q <= 1'b1;
			out_kind_q <= pend_v_q ? KIND_REPORT : KIND_EMPTY;
			out_e_q    <= pend_v_q ? pend_q : '0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {out_e_q.inst, out_e_q.pkts, out_e_q.bytes, out_e_q.port,
		out_e_q.proto, out_e_q.addr};

	assign st.is_tick    = (s_tuser[0] == CMD_TICK);
	assign st.no_flows   = (order_count_q == '0);
	assign st.ord_done   = (k_q == order_count_q);
	assign st.slot_valid = valid_q[slot_q];
	assign st.life_le1   = (rd_q.life <= 8'd1);
	assign st.pend_v     = pend_v_q;
	assign st.out_free   = out_free;

	// The compacted order never runs ahead of the walk
	a_keep_le_k: assert property (@(posedge clk) disable iff (!arst_n)
		keep_q <= k_q) else $error("order compaction overtook the walk");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		order_count_q <= CW'(ENTRIES)) else $error("flow count beyond table size");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |=> (m_tvalid && m_tlast)) else $error("tick ended without a final result");

endmodule

// File: hdl/flow_accounting_table.sv
// Flow accounting table. Packets (tuser 0) are matched against all stored flows
// in parallel and pass through capture, key compare and counter update. A tick
// (tuser 1) is captured, then walks the stored flows in age order, each through
// registered reads of the order and entry memories and a processing step, and
// closes with a final step, which follows capture directly with no stored flows.
// Results wait in one output register, so a stalled receiver holds the packet
// update or the tick walk. A tick yields one report per surviving flow, or a
// single empty report. The ttl_reload register lies at APB byte address 0.
module flow_accounting_table
	import flt_pkg::*;
#(
	parameter int ENTRIES = 64
)
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,   // src_addr, proto_code, src_port, byte_count
	input  logic [0:0]   s_tuser,   // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,   // flow_addr, flow_proto, flow_port, flow_bytes,
	                                // flow_pkts, instance_no
	output logic [2:0]   m_tuser,   // kind
	output logic         m_tlast,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [7:0] ttl_q;
	cmd_t       cmd;
	status_t    st;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TTL_RESET;
		end else if (psel && penable && pwrite && (paddr == ADDR_TTL_RELOAD)) begin
			ttl_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_TTL_RELOAD) ? {24'd0, ttl_q} : 32'd0;

	flt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	flt_dpath #(.ENTRIES(ENTRIES)) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.ttl      (ttl_q),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

// File: test/tb_flow_accounting_table.sv
`timescale 1ns / 1ps

module tb_flow_accounting_table;
	import flt_pkg::*;

	localparam int NSLOT = 64;
	localparam longint CYCLE_LIMIT = 2000000;

	// Input and result transactions as unpacked fields
	typedef struct {
		logic        cmd;
		logic [31:0] addr;
		logic [8:0]  proto;
		logic [15:0] port;
		logic [16:0] bytes;
	} pkt_item_t;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] addr;
		logic [8:0]  proto;
		logic [15:0] port;
		logic [31:0] bytes;
		logic [31:0] pkts;
		logic [6:0]  inst;
		logic        last;
	} flow_res_t;

	// Directed row: item plus an optional typed-in result
	typedef struct {
		pkt_item_t item;
		bit        has_res;
		flow_res_t res;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [79:0]  s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	flow_accounting_table dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the flow table
	logic [7:0]  ttl_shadow;
	bit          tbl_valid [NSLOT];
	logic [31:0] tbl_addr  [NSLOT];
	logic [8:0]  tbl_proto [NSLOT];
	logic [15:0] tbl_port  [NSLOT];
	logic [31:0] tbl_bytes [NSLOT];
	logic [31:0] tbl_pkts  [NSLOT];
	logic [6:0]  tbl_inst  [NSLOT];
	logic [7:0]  tbl_life  [NSLOT];
	int          age_order [NSLOT];
	int          flow_count;

	flow_res_t expected_flows [$];
	flow_res_t typed_res [$];
	bit        typed_has [$];

	int     mismatches;
	longint cycles;
	int     send_idle_pct;
	int     recv_stall_pct;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic flow_res_t mk_res(logic [2:0] k, logic [31:0] a, logic [8:0] pr,
	                                     logic [15:0] po, logic [31:0] b, logic [31:0] p,
	                                     logic [6:0] in, logic l);
		flow_res_t r;
		r.kind = k; r.addr = a; r.proto = pr; r.port = po;
		r.bytes = b; r.pkts = p; r.inst = in; r.last = l;
		return r;
	endfunction

	// Predict the results of one transaction and update the shadow table
	task automatic account_item(input pkt_item_t it);
		int same;
		int slot;
		int keep;
		int n;
		if (it.cmd == CMD_PACKET) begin
			same = 0;
			for (int i = 0; i < NSLOT; i++) begin
				if (tbl_valid[i] && tbl_addr[i] == it.addr) begin
					same++;
					if (tbl_port[i] == it.port && tbl_proto[i] == it.proto) begin
						tbl_bytes[i] = sat_inc(tbl_bytes[i], {15'd0, it.bytes});
						tbl_pkts[i] = sat_inc(tbl_pkts[i], 32'd1);
						expected_flows.push_back(mk_res(KIND_COUNTED, it.addr, it.proto,
							it.port, tbl_bytes[i], tbl_pkts[i], tbl_inst[i], 1'b1));
						return;
					end
				end
			end
			slot = -1;
			for (int i = NSLOT - 1; i >= 0; i--)
				if (!tbl_valid[i])
					slot = i;
			if (flow_count >= NSLOT || slot < 0) begin
				expected_flows.push_back(mk_res(KIND_DROPPED, it.addr, it.proto, it.port,
					32'd0, 32'd0, 7'd0, 1'b1));
				return;
			end
			tbl_valid[slot] = 1'b1;
			tbl_addr[slot] = it.addr;
			tbl_proto[slot] = it.proto;
			tbl_port[slot] = it.port;
			tbl_bytes[slot] = {15'd0, it.bytes};
			tbl_pkts[slot] = 32'd1;
			tbl_inst[slot] = 7'(same + 1);
			tbl_life[slot] = ttl_shadow;
			age_order[flow_count] = slot;
			flow_count++;
			expected_flows.push_back(mk_res(KIND_NEW, it.addr, it.proto, it.port,
				{15'd0, it.bytes}, 32'd1, tbl_inst[slot], 1'b1));
		end else begin
			keep = 0;
			n = 0;
			for (int k = 0; k < flow_count; k++) begin
				slot = age_order[k];
				if (!tbl_valid[slot])
					continue;
				if (tbl_life[slot] <= 8'd1) begin
					tbl_valid[slot] = 1'b0;
					continue;
				end
				tbl_life[slot]--;
				expected_flows.push_back(mk_res(KIND_REPORT, tbl_addr[slot], tbl_proto[slot],
					tbl_port[slot], tbl_bytes[slot], tbl_pkts[slot], tbl_inst[slot], 1'b0));
				n++;
				if (tbl_bytes[slot] != 0)
					tbl_life[slot] = ttl_shadow;
				tbl_bytes[slot] = 0;
				tbl_pkts[slot] = 0;
				age_order[keep] = slot;
				keep++;
			end
			flow_count = keep;
			if (n == 0)
				expected_flows.push_back(mk_res(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 1'b1));
			else
				expected_flows[$].last = 1'b1;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	// Result checker on the master side
	always @(posedge clk) begin
		flow_res_t g;
		flow_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			g = mk_res(m_tuser, m_tdata[31:0], m_tdata[40:32], m_tdata[56:41],
				m_tdata[88:57], m_tdata[120:89], m_tdata[127:121], m_tlast);
			if (expected_flows.size() == 0) begin
				report_mismatch("unexpected result kind", g.kind, 0);
			end else begin
				e = expected_flows.pop_front();
				if (typed_has.size() > 0 && g.last) begin
					if (typed_has.pop_front()) begin
						if (typed_res[0] != e)
							report_mismatch("directed table row", g.kind, typed_res[0].kind);
						void'(typed_res.pop_front());
					end
				end
				if (g.kind !== e.kind) report_mismatch("kind", g.kind, e.kind);
				if (g.addr !== e.addr) report_mismatch("flow_addr", g.addr, e.addr);
				if (g.proto !== e.proto) report_mismatch("flow_proto", g.proto, e.proto);
				if (g.port !== e.port) report_mismatch("flow_port", g.port, e.port);
				if (g.bytes !== e.bytes) report_mismatch("flow_bytes", g.bytes, e.bytes);
				if (g.pkts !== e.pkts) report_mismatch("flow_pkts", g.pkts, e.pkts);
				if (g.inst !== e.inst) report_mismatch("instance_no", g.inst, e.inst);
				if (g.last !== e.last) report_mismatch("last", g.last, e.last);
			end
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Send one transaction, with random idle cycles before it; the block is busy in
	// the cycle after an accepted transaction, so tvalid drops for that cycle
	task automatic send_item(input pkt_item_t it);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, it.bytes, it.port, it.proto, it.addr};
		s_tuser <= it.cmd;
		account_item(it);
		do
			@(posedge clk);
		while (!s_tready);
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_flows.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_ttl(input logic [7:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_TTL_RELOAD; pwdata <= {24'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		ttl_shadow = v;
	endtask

	function automatic pkt_item_t mk_item(logic c, logic [31:0] a, logic [8:0] pr,
	                                      logic [15:0] po, logic [16:0] b);
		pkt_item_t it;
		it.cmd = c; it.addr = a; it.proto = pr; it.port = po; it.bytes = b;
		return it;
	endfunction

	// Random item: mostly packets from a small pool of flows, some wild keys, some ticks
	function automatic pkt_item_t rand_item(int pool);
		pkt_item_t it;
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return mk_item(CMD_TICK, $urandom, $urandom, $urandom, $urandom);
		if (r < 25)
			return mk_item(CMD_PACKET, $urandom, 9'($urandom), 16'($urandom),
				17'($urandom_range(65549)));
		it = mk_item(CMD_PACKET, 32'h0A00_0000 + $urandom_range(3), 9'($urandom_range(pool % 3)),
			16'($urandom_range(pool)), 17'($urandom_range(1)) == 0 ? 17'd0 :
			17'($urandom_range(65549)));
		if ($urandom_range(9) == 0)
			it.proto = 9'h1FF;
		return it;
	endfunction

	dir_row_t dir_rows [$];

	initial begin
		pkt_item_t it;
		int idle_sets [4][2] = '{'{0, 0}, '{64, 0}, '{0, 64}, '{14, 14}};
		cycles = 0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		ttl_shadow = TTL_RESET;
		flow_count = 0;
		for (int i = 0; i < NSLOT; i++)
			tbl_valid[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty tick, extremes, SSH code, repeat hit, ageing out
		dir_rows.push_back('{mk_item(CMD_TICK, 0, 0, 0, 0), 1,
			mk_res(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 1)});
		dir_rows.push_back('{mk_item(CMD_PACKET, 32'hFFFF_FFFF, 9'h1FF, 16'hFFFF, 17'h1FFFF), 1,
			mk_res(KIND_NEW, 32'hFFFF_FFFF, 9'h1FF, 16'hFFFF, 32'h1FFFF, 1, 1, 1)});
		dir_rows.push_back('{mk_item(CMD_PACKET, 0, 0, 0, 0), 1,
			mk_res(KIND_NEW, 0, 0, 0, 0, 1, 1, 1)});
		dir_rows.push_back('{mk_item(CMD_PACKET, 32'hFFFF_FFFF, 9'd255, 16'd22, 17'd65549), 0,
			mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
		dir_rows.push_back('{mk_item(CMD_PACKET, 32'hFFFF_FFFF, 9'h1FF, 16'hFFFF, 17'd100), 0,
			mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
		dir_rows.push_back('{mk_item(CMD_PACKET, 32'h0000_0000, 9'd6, 16'd80, 17'd60), 0,
			mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
		for (int i = 0; i < 4; i++)
			dir_rows.push_back('{mk_item(CMD_TICK, 0, 0, 0, 0), 0,
				mk_res(0, 0, 0, 0, 0, 0, 0, 0)});
		dir_rows.push_back('{mk_item(CMD_TICK, 0, 0, 0, 0), 1,
			mk_res(KIND_EMPTY, 0, 0, 0, 0, 0, 0, 1)});
		foreach (dir_rows[i]) begin
			typed_has.push_back(dir_rows[i].has_res);
			if (dir_rows[i].has_res)
				typed_res.push_back(dir_rows[i].res);
			send_item(dir_rows[i].item);
		end
		drain();

		// Table full: 64 distinct flows, then two more are dropped
		write_ttl(8'd255);
		for (int i = 0; i < NSLOT + 2; i++)
			send_item(mk_item(CMD_PACKET, 32'hC0A8_0001, 9'd17, 16'(i), 17'h1FFFF));
		for (int i = 0; i < 3; i++)
			send_item(mk_item(CMD_TICK, 0, 0, 0, 0));
		drain();
		write_ttl(8'd0);
		send_item(mk_item(CMD_PACKET, 32'h1, 9'd1, 16'd1, 17'd1));
		send_item(mk_item(CMD_TICK, 0, 0, 0, 0));
		send_item(mk_item(CMD_TICK, 0, 0, 0, 0));
		drain();

		// Random phases over idling patterns and lifetimes
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_sets[ph][0];
			recv_stall_pct = idle_sets[ph][1];
			case (ph)
				0: write_ttl(8'd1);
				1: write_ttl(8'd2);
				2: write_ttl(8'($urandom_range(3, 254)));
				default: write_ttl(8'd255);
			endcase
			for (int n = 0; n < 15; n++)
				send_item(rand_item(4 + ph * 6));
			drain();
		end

		if (mismatches == 0 && expected_flows.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: files.f
hdl/flt_pkg.sv
hdl/flt_ctrl.sv
hdl/flt_dpath.sv
hdl/flow_accounting_table.sv
test/tb_flow_accounting_table.sv
